// File: hdl/sps_pkg.sv
// shared types, codes and sizes for the scripted pad step sequencer
package sps_pkg;

    localparam int MAX_STEPS     = 64;
    localparam int COUNT_BITS    = 24;
    localparam int STEP_IDX_BITS = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
    localparam int PTR_BITS      = $clog2(MAX_STEPS + 1);
    localparam int CNT_BITS      = COUNT_BITS + 1;
    localparam int NEUTRAL_POLLS = 2;

    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_APPEND = 2'd1;
    localparam logic [1:0] ACT_POLL   = 2'd2;

    localparam logic [1:0] KIND_PRESS     = 2'd0;
    localparam logic [1:0] KIND_STICK     = 2'd1;
    localparam logic [1:0] KIND_WAIT_POLL = 2'd2;
    localparam logic [1:0] KIND_WAIT_FLAG = 2'd3;

    localparam logic [1:0] AXIS_LEFT_X  = 2'd0;
    localparam logic [1:0] AXIS_LEFT_Y  = 2'd1;
    localparam logic [1:0] AXIS_RIGHT_X = 2'd2;
    localparam logic [1:0] AXIS_RIGHT_Y = 2'd3;

    typedef struct packed {
        logic [1:0]            kind;
        logic [15:0]           buttons;
        logic [1:0]            axis;
        logic [15:0]           level;
        logic [COUNT_BITS-1:0] count;
        logic                  want;
    } t_step;

    localparam int STEP_BITS = $bits(t_step);

    typedef struct packed {
        logic                     we;
        logic [STEP_IDX_BITS-1:0] addr;
        t_step                    data;
    } t_tbl_wr;

endpackage

// File: hdl/sps_ram.sv
// generic single-port-write ram with registered read
module sps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/sps_table.sv
// step table: ram plus write-to-read bypass, presents the step at the pointer
module sps_table (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  sps_pkg::t_tbl_wr                     i_wr,
    input  logic [sps_pkg::STEP_IDX_BITS-1:0]    i_rd_addr,
    output sps_pkg::t_step                       o_step
);
    import sps_pkg::*;

    logic [STEP_BITS-1:0] rdata;
    logic                 r_byp_hit;
    t_step                r_byp_data;

    sps_ram #(
        .WIDTH(STEP_BITS),
        .DEPTH(MAX_STEPS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (i_wr.we),
        .i_waddr(i_wr.addr),
        .i_wdata(i_wr.data),
        .i_raddr(i_rd_addr),
        .o_rdata(rdata)
    );

    // same-cycle write to the address being read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp_hit <= 1'b0;
        end else begin
            r_byp_hit <= i_wr.we && (i_wr.addr == i_rd_addr);
        end
        r_byp_data <= i_wr.data;
    end

    assign o_step = r_byp_hit ? r_byp_data : t_step'(rdata);

endmodule

// File: hdl/scripted_pad_step_sequencer.sv
// top level of the scripted pad step sequencer
// Takes one action per transfer: clear the program, append one step, or poll.
// Each poll yields exactly one pad state, registered and offered on the output
// channel in the cycle after the poll is taken; clear and append yield nothing.
// One action is taken every cycle while the output register is free or being
// drained; the input stalls only while a result is held by a stalled output.
// The step table is a 64-entry ram read every cycle at the next step pointer,
// so the current step is always ready when the next poll arrives.
module scripted_pad_step_sequencer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [1:0]                        i_action,
    input  logic [1:0]                        i_step_kind,
    input  logic [15:0]                       i_step_buttons,
    input  logic [1:0]                        i_step_axis,
    input  logic signed [15:0]                i_step_axis_level,
    input  logic [sps_pkg::COUNT_BITS-1:0]    i_step_count,
    input  logic                              i_step_flag_want,
    input  logic                              i_level_flag,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [15:0]                       o_pad_buttons,
    output logic signed [15:0]                o_left_x,
    output logic signed [15:0]                o_left_y,
    output logic signed [15:0]                o_right_x,
    output logic signed [15:0]                o_right_y,
    output logic                              o_program_done,
    output logic                              o_program_failed
);
    import sps_pkg::*;

    logic [PTR_BITS-1:0]   r_total, n_total;
    logic [PTR_BITS-1:0]   r_ptr, n_ptr;
    logic [CNT_BITS-1:0]   r_cnt, n_cnt;
    logic [COUNT_BITS-1:0] r_tmo, n_tmo;
    logic                  r_tmo_vld, n_tmo_vld;
    logic                  r_failed, n_failed;
    logic                  r_out_valid, n_out_valid;

    logic [15:0] r_buttons, n_buttons;
    logic [15:0] r_lx, n_lx, r_ly, n_ly, r_rx, n_rx, r_ry, n_ry;
    logic        r_done, n_done;
    logic        r_fail_out, n_fail_out;

    logic                  accept;
    logic                  is_poll;
    t_tbl_wr               wr;
    t_step                 cur;
    logic [CNT_BITS-1:0]   cnt_inc;
    logic [CNT_BITS-1:0]   count_ext;
    logic [COUNT_BITS-1:0] tmo_now;

    sps_table u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (wr),
        .i_rd_addr(n_ptr[STEP_IDX_BITS-1:0]),
        .o_step   (cur)
    );

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;
    assign is_poll    = accept && (i_action == ACT_POLL);
    assign cnt_inc    = r_cnt + CNT_BITS'(1);
    assign count_ext  = CNT_BITS'(cur.count);
    assign tmo_now    = r_tmo_vld ? r_tmo : cur.count;

    always_comb begin
        n_total   = r_total;
        n_ptr     = r_ptr;
        n_cnt     = r_cnt;
        n_tmo     = r_tmo;
        n_tmo_vld = r_tmo_vld;
        n_failed  = r_failed;
        n_buttons = '0;
        n_lx      = '0;
        n_ly      = '0;
        n_rx      = '0;
        n_ry      = '0;

        wr.we           = accept && (i_action == ACT_APPEND)
                          && (r_total < PTR_BITS'(MAX_STEPS));
        wr.addr         = r_total[STEP_IDX_BITS-1:0];
        wr.data.kind    = i_step_kind;
        wr.data.buttons = i_step_buttons;
        wr.data.axis    = i_step_axis;
        wr.data.level   = i_step_axis_level;
        wr.data.count   = i_step_count;
        wr.data.want    = i_step_flag_want;

        if (accept) begin
            case (i_action)
                ACT_CLEAR: begin
                    n_total   = '0;
                    n_ptr     = '0;
                    n_cnt     = '0;
                    n_tmo_vld = 1'b0;
                    n_failed  = 1'b0;
                end
                ACT_APPEND: begin
                    if (wr.we) begin
                        n_total = r_total + PTR_BITS'(1);
                    end
                end
                ACT_POLL: begin
                    if (!r_failed && (r_ptr < r_total)) begin
                        case (cur.kind)
                            KIND_PRESS, KIND_STICK: begin
                                if (r_cnt < count_ext) begin
                                    if (cur.kind == KIND_PRESS) begin
                                        n_buttons = cur.buttons;
                                    end else begin
                                        case (cur.axis)
                                            AXIS_LEFT_X:  n_lx = cur.level;
                                            AXIS_LEFT_Y:  n_ly = cur.level;
                                            AXIS_RIGHT_X: n_rx = cur.level;
                                            AXIS_RIGHT_Y: n_ry = cur.level;
                                            default:      n_lx = cur.level;
                                        endcase
                                    end
                                end
                                n_cnt = cnt_inc;
                                if (cnt_inc >= count_ext + CNT_BITS'(NEUTRAL_POLLS)) begin
                                    n_ptr     = r_ptr + PTR_BITS'(1);
                                    n_cnt     = '0;
                                    n_tmo_vld = 1'b0;
                                end
                            end
                            KIND_WAIT_POLL: begin
                                n_cnt = cnt_inc;
                                if (cnt_inc >= count_ext) begin
                                    n_ptr     = r_ptr + PTR_BITS'(1);
                                    n_cnt     = '0;
                                    n_tmo_vld = 1'b0;
                                end
                            end
                            default: begin
                                if (i_level_flag == cur.want) begin
                                    n_ptr     = r_ptr + PTR_BITS'(1);
                                    n_cnt     = '0;
                                    n_tmo_vld = 1'b0;
                                end else if (tmo_now == '0) begin
                                    n_failed  = 1'b1;
                                    n_tmo     = tmo_now;
                                    n_tmo_vld = 1'b1;
                                end else begin
                                    n_tmo     = tmo_now - COUNT_BITS'(1);
                                    n_tmo_vld = 1'b1;
                                end
                            end
                        endcase
                    end
                end
                default: begin
                end
            endcase
        end

        n_done     = !n_failed && (n_ptr >= n_total);
        n_fail_out = n_failed;

        if (is_poll) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= '0;
            r_ptr       <= '0;
            r_cnt       <= '0;
            r_tmo_vld   <= 1'b0;
            r_failed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_total     <= n_total;
            r_ptr       <= n_ptr;
            r_cnt       <= n_cnt;
            r_tmo_vld   <= n_tmo_vld;
            r_failed    <= n_failed;
            r_out_valid <= n_out_valid;
        end
        r_tmo <= n_tmo;
        if (is_poll) begin
            r_buttons  <= n_buttons;
            r_lx       <= n_lx;
            r_ly       <= n_ly;
            r_rx       <= n_rx;
            r_ry       <= n_ry;
            r_done     <= n_done;
            r_fail_out <= n_fail_out;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_pad_buttons    = r_buttons;
    assign o_left_x         = $signed(r_lx);
    assign o_left_y         = $signed(r_ly);
    assign o_right_x        = $signed(r_rx);
    assign o_right_y        = $signed(r_ry);
    assign o_program_done   = r_done;
    assign o_program_failed = r_fail_out;

endmodule

// File: hdl/sps_checker.sv
// port-level assertions for the scripted pad step sequencer, bound to the top
module sps_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              o_in_stall,
    input  logic [1:0]                        i_action,
    input  logic                              o_out_valid,
    input  logic                              i_out_stall,
    input  logic [15:0]                       o_pad_buttons,
    input  logic signed [15:0]                o_left_x,
    input  logic signed [15:0]                o_left_y,
    input  logic signed [15:0]                o_right_x,
    input  logic signed [15:0]                o_right_y,
    input  logic                              o_program_done,
    input  logic                              o_program_failed
);
    import sps_pkg::*;

    logic in_xfer;
    logic out_hold;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_hold = o_out_valid && i_out_stall;

    a_done_fail_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_program_done && o_program_failed))
        else $error("done and failed reported together");

    a_end_neutral: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_program_done || o_program_failed)) |->
        (o_pad_buttons == '0 && o_left_x == '0 && o_left_y == '0
         && o_right_x == '0 && o_right_y == '0))
        else $error("pad not neutral at program end");

    a_poll_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_action == ACT_POLL) |=> o_out_valid)
        else $error("poll transfer produced no result");

    a_no_spurious_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_action != ACT_POLL && !out_hold) |=> !o_out_valid)
        else $error("result without a poll");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_hold |=> (o_out_valid && $stable(o_pad_buttons) && $stable(o_left_x)
        && $stable(o_left_y) && $stable(o_right_x) && $stable(o_right_y)
        && $stable(o_program_done) && $stable(o_program_failed)))
        else $error("stalled result changed");

endmodule

bind scripted_pad_step_sequencer sps_checker u_sps_checker (.*);
